FILE: rtl/cth_pkg.sv
// Shared types, codes and fixed widths of the cache tag hit/miss model.
package cth_pkg;

  localparam int TAG_W   = 30;
  localparam int STAMP_W = 32;
  localparam int SET_W   = 15;
  localparam int PADDR_W = 5;

  localparam logic [1:0] MAP_DIRECT = 2'd0;
  localparam logic [1:0] MAP_SET    = 2'd1;
  localparam logic [1:0] MAP_FULL   = 2'd2;
  localparam logic [1:0] MAP_SPARE  = 2'd3;

  localparam logic [1:0] POL_FIFO   = 2'd0;
  localparam logic [1:0] POL_LIFO   = 2'd1;
  localparam logic [1:0] POL_MRU    = 2'd2;
  localparam logic [1:0] POL_RANDOM = 2'd3;

  localparam logic [1:0] MISS_NONE       = 2'd0;
  localparam logic [1:0] MISS_COMPULSORY = 2'd1;
  localparam logic [1:0] MISS_CONFLICT   = 2'd2;
  localparam logic [1:0] MISS_CAPACITY   = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [2:0] REG_MAPPING = 3'd0;
  localparam logic [2:0] REG_WBACK   = 3'd1;
  localparam logic [2:0] REG_POLICY  = 3'd2;
  localparam logic [2:0] REG_OFFSET  = 3'd3;
  localparam logic [2:0] REG_INDEX   = 3'd4;
  localparam logic [2:0] REG_WAYS    = 3'd5;

  localparam logic [31:0] RNG_Z_INIT = 32'h0508_0902;
  localparam logic [31:0] RNG_W_INIT = 32'hABAB_AB55;
  localparam logic [15:0] RNG_Z_MUL  = 16'd36969;
  localparam logic [15:0] RNG_W_MUL  = 16'd18000;
  localparam logic [15:0] RNG_LOW    = 16'd65535;

  typedef struct packed {
    logic        operation;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] miss_kind;
    logic       dirty_writeback;
    logic       mem_write_through;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  mapping_mode;
    logic        write_back_mode;
    logic [1:0]  replace_policy;
    logic [2:0]  offset_bits;
    logic [3:0]  index_bits;
    logic [10:0] ways_in_use;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE,
    ST_SCAN,
    ST_DECIDE,
    ST_RAND,
    ST_RAND_MOD,
    ST_RAND_WAIT,
    ST_VREAD,
    ST_VWRITE
  } state_t;

endpackage

FILE: rtl/cth_tag_ram.sv
// Tag store memory: one write port, one read port with registered data.
module cth_tag_ram import cth_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          rd_en,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cth_mod.sv
// Serial remainder unit: one dividend bit per cycle.
module cth_mod #(
  parameter int DV_W = 11
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [31:0]     dividend,
  input  logic [DV_W-1:0] divisor,
  output logic            done,
  output logic [DV_W-1:0] rem
);

  logic            active;
  logic [4:0]      cnt;
  logic [31:0]     quo;
  logic [DV_W-1:0] dv;
  logic [DV_W:0]   trial;
  logic [DV_W-1:0] rem_next;

  always_comb begin
    trial = {rem, quo[31]};
    if (trial >= {1'b0, dv}) begin
      rem_next = DV_W'(trial - {1'b0, dv});
    end else begin
      rem_next = DV_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      done   <= 1'b0;
      cnt    <= '0;
      quo    <= dividend;
      dv     <= divisor;
      rem    <= '0;
    end else if (active) begin
      rem  <= rem_next;
      quo  <= {quo[30:0], 1'b0};
      cnt  <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

FILE: rtl/cth_regs.sv
// Configuration register file behind the APB-style port.
module cth_regs import cth_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mapping_mode    <= MAP_DIRECT;
      cfg.write_back_mode <= 1'b0;
      cfg.replace_policy  <= POL_FIFO;
      cfg.offset_bits     <= 3'd2;
      cfg.index_bits      <= 4'd10;
      cfg.ways_in_use     <= 11'd1;
    end else if (wr) begin
      unique case (idx)
        REG_MAPPING: cfg.mapping_mode    <= pwdata[1:0];
        REG_WBACK:   cfg.write_back_mode <= pwdata[0];
        REG_POLICY:  cfg.replace_policy  <= pwdata[1:0];
        REG_OFFSET:  cfg.offset_bits     <= pwdata[2:0];
        REG_INDEX:   cfg.index_bits      <= pwdata[3:0];
        REG_WAYS:    cfg.ways_in_use     <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAPPING: prdata = {30'd0, cfg.mapping_mode};
      REG_WBACK:   prdata = {31'd0, cfg.write_back_mode};
      REG_POLICY:  prdata = {30'd0, cfg.replace_policy};
      REG_OFFSET:  prdata = {29'd0, cfg.offset_bits};
      REG_INDEX:   prdata = {28'd0, cfg.index_bits};
      REG_WAYS:    prdata = {21'd0, cfg.ways_in_use};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/cache_tag_hit_miss_model.sv
// Top level: sequencer that walks the tag store memory for each access.
// Each access steps through set base (direct mapped and set associative), the
// tag walk over the ways in use (one way when direct mapped), victim decision,
// a random victim draw on a fully associative random-policy replacement, victim
// read and victim write. The walk over the tag store, one entry per cycle on
// the memory read port, sets the rate; the next access is taken the cycle after
// the result. Reset: synchronous; then all blocks are cleared, busy high.
// Results appear for one cycle on done; the receiver cannot stall them.
module cache_tag_hit_miss_model import cth_pkg::*; #(
  parameter int NUM_BLOCKS   = 1024,
  parameter int MAX_SET_WAYS = 16,
  parameter int ADDR_BITS    = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  req_t               req,
  output logic               done,
  output rsp_t               rsp
);

  localparam int AW    = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ADDR_BITS) - 32'd1);

  cfg_t cfg;

  cth_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Tag store: valid, dirty, tag and age stamp in one word per block.
  logic          we, rd_en;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  cth_tag_ram #(.DEPTH(NUM_BLOCKS), .AW(AW)) u_ram (
    .clk, .we, .waddr, .wdata, .rd_en, .raddr, .rdata
  );

  // Remainder unit: random pick mod the block count in use.
  logic             mod_start, mod_done;
  logic [31:0]      mod_dividend;
  logic [CNT_W-1:0] mod_divisor, mod_rem;

  cth_mod #(.DV_W(CNT_W)) u_mod (
    .clk, .rst, .start(mod_start), .dividend(mod_dividend),
    .divisor(mod_divisor), .done(mod_done), .rem(mod_rem)
  );

  state_t state, state_next;

  // Per-access registers.
  logic [1:0]       mode_r;
  logic             is_write;
  logic [TAG_W-1:0] tag_r;
  logic [SET_W-1:0] set_r;
  logic [CNT_W-1:0] n_r;

  // Walk registers.
  logic [AW-1:0]      ptr;
  logic [CNT_W-1:0]   issue_k, pk;
  logic               pv;
  logic [AW-1:0]      ps;
  logic               found, empty_f;
  logic [AW-1:0]      hslot, eslot, bslot, slot_v;
  logic [STAMP_W-1:0] best;

  logic       hit_r, replacing;
  logic [1:0] kind_r;

  logic [31:0] insert_count, use_count, rng_z, rng_w;

  // Address split at the input transfer.
  logic [31:0]      addr_m;
  logic [2:0]       off;
  logic [4:0]       sh;
  logic [1:0]       mode_in;
  logic [10:0]      ways;
  logic [CNT_W-1:0] n_in;
  logic [AW-1:0]    ptr_inc;
  logic             use_min, mru, fa, issuing;

  always_comb begin
    addr_m  = req.address & ADDR_MASK;
    off     = (cfg.offset_bits < 3'd2) ? 3'd2 : cfg.offset_bits;
    sh      = 5'(off) + 5'(cfg.index_bits);
    mode_in = (cfg.mapping_mode == MAP_SPARE) ? MAP_FULL : cfg.mapping_mode;
    ways    = (cfg.ways_in_use == 11'd0) ? 11'd1 : cfg.ways_in_use;
    case (mode_in)
      MAP_DIRECT: n_in = CNT_W'(1);
      MAP_SET:    n_in = (32'(ways) > MAX_SET_WAYS) ? CNT_W'(MAX_SET_WAYS) : CNT_W'(ways);
      default:    n_in = (32'(ways) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(ways);
    endcase
  end

  assign ptr_inc = (32'(ptr) == NUM_BLOCKS - 1) ? '0 : ptr + AW'(1);
  assign mru     = (cfg.replace_policy == POL_MRU);
  assign fa      = (mode_r == MAP_FULL);
  assign use_min = (mode_r == MAP_SET) || (cfg.replace_policy == POL_FIFO);
  assign issuing = (issue_k < n_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    busy         = (state != ST_IDLE);
    done         = 1'b0;
    we           = 1'b0;
    waddr        = ptr;
    wdata        = '0;
    rd_en        = 1'b0;
    raddr        = ptr;
    mod_start    = 1'b0;
    mod_dividend = (rng_z << 16) + rng_w;
    mod_divisor  = n_r;
    rsp          = '0;
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
        if (32'(ptr) == NUM_BLOCKS - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = (mode_in == MAP_FULL) ? ST_SCAN : ST_BASE;
        end
      end
      ST_BASE: state_next = ST_SCAN;
      ST_SCAN: begin
        rd_en = issuing;
        if (!issuing && !pv) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!found && fa && (insert_count >= 32'(n_r))
            && (cfg.replace_policy == POL_RANDOM)) begin
          state_next = ST_RAND;
        end else begin
          state_next = ST_VREAD;
        end
      end
      ST_RAND: state_next = ST_RAND_MOD;
      ST_RAND_MOD: begin
        mod_start  = 1'b1;
        state_next = ST_RAND_WAIT;
      end
      ST_RAND_WAIT: begin
        if (mod_done) begin
          state_next = ST_VREAD;
        end
      end
      ST_VREAD: begin
        rd_en      = 1'b1;
        raddr      = slot_v;
        state_next = ST_VWRITE;
      end
      ST_VWRITE: begin
        we          = 1'b1;
        waddr       = slot_v;
        done        = 1'b1;
        wdata.valid = 1'b1;
        wdata.tag   = tag_r;
        if (hit_r) begin
          wdata.dirty = (is_write && cfg.write_back_mode) ? 1'b1 : rdata.dirty;
          wdata.stamp = (fa && mru) ? use_count : rdata.stamp;
        end else begin
          wdata.dirty = 1'b0;
          if (mode_r == MAP_DIRECT) begin
            wdata.stamp = rdata.stamp;
          end else if (fa && mru) begin
            wdata.stamp = use_count;
          end else begin
            wdata.stamp = insert_count;
          end
        end
        rsp.hit               = hit_r;
        rsp.miss_kind         = kind_r;
        rsp.dirty_writeback   = !hit_r && replacing && cfg.write_back_mode && rdata.dirty;
        rsp.mem_write_through = hit_r && is_write && !cfg.write_back_mode;
        state_next            = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers: clear pointer, counters and generator.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr          <= '0;
      pv           <= 1'b0;
      insert_count <= '0;
      use_count    <= '0;
      rng_z        <= RNG_Z_INIT;
      rng_w        <= RNG_W_INIT;
    end else begin
      case (state)
        ST_CLEAR: ptr <= ptr_inc;
        ST_IDLE: begin
          ptr <= '0;
          pv  <= 1'b0;
        end
        // Set base; the block count is a power of two, so truncation wraps it.
        ST_BASE: ptr <= AW'(32'(set_r) * 32'(n_r));
        ST_SCAN: begin
          pv <= issuing;
          if (issuing) begin
            ptr <= ptr_inc;
          end
        end
        ST_RAND: begin
          rng_z <= 32'(RNG_Z_MUL) * 32'(rng_z[15:0]) + (rng_z >> 16);
          rng_w <= 32'(RNG_W_MUL) * 32'(rng_w[15:0]) + (rng_w >> 16);
        end
        ST_VWRITE: begin
          if (hit_r) begin
            if (fa && mru) begin
              use_count <= use_count + 32'd1;
            end
          end else if (mode_r != MAP_DIRECT) begin
            insert_count <= insert_count + 32'd1;
            if (fa && mru) begin
              use_count <= use_count + 32'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Access datapath: capture, walk compares, victim choice.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        mode_r   <= mode_in;
        is_write <= (req.operation == OP_WRITE);
        tag_r    <= TAG_W'(addr_m >> sh);
        set_r    <= SET_W'((addr_m >> off) & ((32'd1 << cfg.index_bits) - 32'd1));
        n_r      <= n_in;
        issue_k  <= '0;
        found    <= 1'b0;
        empty_f  <= 1'b0;
      end
      ST_SCAN: begin
        if (issuing) begin
          issue_k <= issue_k + CNT_W'(1);
          pk      <= issue_k;
          ps      <= ptr;
        end
        if (pv) begin
          if (rdata.valid && rdata.tag == tag_r && !found) begin
            found <= 1'b1;
            hslot <= ps;
          end
          if (!rdata.valid && !empty_f) begin
            empty_f <= 1'b1;
            eslot   <= ps;
          end
          if (pk == '0 || (use_min ? (rdata.stamp < best) : (rdata.stamp > best))) begin
            best  <= rdata.stamp;
            bslot <= ps;
          end
        end
      end
      ST_DECIDE: begin
        hit_r     <= found;
        replacing <= 1'b0;
        if (found) begin
          slot_v <= hslot;
          kind_r <= MISS_NONE;
        end else if (mode_r == MAP_DIRECT) begin
          slot_v    <= bslot;
          kind_r    <= empty_f ? MISS_COMPULSORY : MISS_CONFLICT;
          replacing <= !empty_f;
        end else if (mode_r == MAP_SET) begin
          slot_v    <= empty_f ? eslot : bslot;
          kind_r    <= empty_f ? MISS_COMPULSORY : MISS_CAPACITY;
          replacing <= !empty_f;
        end else if (insert_count < 32'(n_r)) begin
          slot_v <= insert_count[AW-1:0];
          kind_r <= MISS_COMPULSORY;
        end else begin
          slot_v    <= bslot;
          kind_r    <= MISS_CAPACITY;
          replacing <= 1'b1;
        end
      end
      ST_RAND_WAIT: begin
        if (mod_done) begin
          slot_v <= AW'(mod_rem);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/cth_port_checker.sv
// Port-level checks on the access and result handshakes, bound to the top.
module cth_port_checker import cth_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result transfer while not busy");

  a_take_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted access did not raise busy");

  a_one_result: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe repeated");

  a_hit_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> ((rsp.hit == (rsp.miss_kind == MISS_NONE))
              && !(rsp.mem_write_through && !rsp.hit)
              && !(rsp.dirty_writeback && rsp.hit)))
    else $error("result fields disagree on hit");

endmodule

bind cache_tag_hit_miss_model cth_port_checker u_port_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
